// ===== hw/rtl/cdcd_pkg.sv =====
// shared types, constants and register codes for the click and double-click detector
package cdcd_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int STAMP_WIDTH = 32;

    localparam int CFG_DIST_W  = 17;
    localparam int CFG_TIME_W  = 16;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 8;

    localparam int DIST_W  = COORD_WIDTH + 2;
    localparam int DCMP_W  = (DIST_W > CFG_DIST_W) ? DIST_W : CFG_DIST_W;
    localparam int TCMP_W  = (STAMP_WIDTH > CFG_TIME_W) ? STAMP_WIDTH : CFG_TIME_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_DIST  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_TIME  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_DIST = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_TIME = CFG_INDEX_W'(3);

    localparam logic [CFG_DIST_W-1:0] RST_CLICK_DIST  = CFG_DIST_W'(4);
    localparam logic [CFG_TIME_W-1:0] RST_CLICK_TIME  = CFG_TIME_W'(300);
    localparam logic [CFG_DIST_W-1:0] RST_DOUBLE_DIST = CFG_DIST_W'(8);
    localparam logic [CFG_TIME_W-1:0] RST_DOUBLE_TIME = CFG_TIME_W'(500);

    typedef enum logic [1:0] {
        REQ_FRAME_RST = 2'd0,
        REQ_DOWN      = 2'd1,
        REQ_UP        = 2'd2
    } t_req_type;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic [STAMP_WIDTH-1:0]        stamp_ms;
    } t_event;

    typedef struct packed {
        logic down_seen;
        logic up_seen;
        logic click;
        logic double_click;
    } t_flags;

    typedef struct packed {
        logic [CFG_DIST_W-1:0] click_distance;
        logic [CFG_TIME_W-1:0] click_time_ms;
        logic [CFG_DIST_W-1:0] double_distance;
        logic [CFG_TIME_W-1:0] double_time_ms;
    } t_cfg;

endpackage

// ===== hw/rtl/cdcd_cfg_regs.sv =====
// configuration registers for click and double-click limits
module cdcd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cdcd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cdcd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cdcd_pkg::t_cfg                   o_cfg
);
    import cdcd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.click_distance  <= RST_CLICK_DIST;
            r_cfg.click_time_ms   <= RST_CLICK_TIME;
            r_cfg.double_distance <= RST_DOUBLE_DIST;
            r_cfg.double_time_ms  <= RST_DOUBLE_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLICK_DIST:  r_cfg.click_distance  <= i_cfg_data[CFG_DIST_W-1:0];
                CFG_CLICK_TIME:  r_cfg.click_time_ms   <= i_cfg_data[CFG_TIME_W-1:0];
                CFG_DOUBLE_DIST: r_cfg.double_distance <= i_cfg_data[CFG_DIST_W-1:0];
                CFG_DOUBLE_TIME: r_cfg.double_time_ms  <= i_cfg_data[CFG_TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/cdcd_dist.sv =====
// manhattan distance between two signed points
module cdcd_dist (
    input  logic signed [cdcd_pkg::COORD_WIDTH-1:0] i_ax,
    input  logic signed [cdcd_pkg::COORD_WIDTH-1:0] i_ay,
    input  logic signed [cdcd_pkg::COORD_WIDTH-1:0] i_bx,
    input  logic signed [cdcd_pkg::COORD_WIDTH-1:0] i_by,
    output logic [cdcd_pkg::DIST_W-1:0]             o_dist
);
    import cdcd_pkg::*;

    logic [COORD_WIDTH:0] w_dx;
    logic [COORD_WIDTH:0] w_dy;
    logic [COORD_WIDTH:0] w_adx;
    logic [COORD_WIDTH:0] w_ady;

    assign w_dx  = {i_ax[COORD_WIDTH-1], i_ax} - {i_bx[COORD_WIDTH-1], i_bx};
    assign w_dy  = {i_ay[COORD_WIDTH-1], i_ay} - {i_by[COORD_WIDTH-1], i_by};
    assign w_adx = w_dx[COORD_WIDTH] ? (~w_dx + 1'b1) : w_dx;
    assign w_ady = w_dy[COORD_WIDTH] ? (~w_dy + 1'b1) : w_dy;

    assign o_dist = DIST_W'(w_adx) + DIST_W'(w_ady);

endmodule

// ===== hw/rtl/cdcd_core.sv =====
// press and release state, click qualification and frame flags
module cdcd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  cdcd_pkg::t_event i_event,
    input  cdcd_pkg::t_cfg   i_cfg,
    output cdcd_pkg::t_flags o_flags
);
    import cdcd_pkg::*;

    logic signed [COORD_WIDTH-1:0] r_press_x, n_press_x;
    logic signed [COORD_WIDTH-1:0] r_press_y, n_press_y;
    logic [STAMP_WIDTH-1:0]        r_press_stamp, n_press_stamp;
    logic signed [COORD_WIDTH-1:0] r_first_x, n_first_x;
    logic signed [COORD_WIDTH-1:0] r_first_y, n_first_y;
    logic [STAMP_WIDTH-1:0]        r_first_stamp, n_first_stamp;
    logic                          r_awaiting, n_awaiting;
    t_flags                        r_flags, n_flags;

    logic [DIST_W-1:0]      w_dist_press;
    logic [DIST_W-1:0]      w_dist_first;
    logic [STAMP_WIDTH-1:0] w_el_press;
    logic [STAMP_WIDTH-1:0] w_el_first;
    logic                   w_click_ok;
    logic                   w_double_ok;

    cdcd_dist u_dist_press (
        .i_ax   (i_event.pos_x),
        .i_ay   (i_event.pos_y),
        .i_bx   (r_press_x),
        .i_by   (r_press_y),
        .o_dist (w_dist_press)
    );

    cdcd_dist u_dist_first (
        .i_ax   (i_event.pos_x),
        .i_ay   (i_event.pos_y),
        .i_bx   (r_first_x),
        .i_by   (r_first_y),
        .o_dist (w_dist_first)
    );

    assign w_el_press = i_event.stamp_ms - r_press_stamp;
    assign w_el_first = i_event.stamp_ms - r_first_stamp;

    assign w_click_ok  = (DCMP_W'(w_dist_press) <= DCMP_W'(i_cfg.click_distance))
                      && (TCMP_W'(w_el_press) <= TCMP_W'(i_cfg.click_time_ms));
    assign w_double_ok = (DCMP_W'(w_dist_first) <= DCMP_W'(i_cfg.double_distance))
                      && (TCMP_W'(w_el_first) <= TCMP_W'(i_cfg.double_time_ms));

    always_comb begin
        n_press_x     = r_press_x;
        n_press_y     = r_press_y;
        n_press_stamp = r_press_stamp;
        n_first_x     = r_first_x;
        n_first_y     = r_first_y;
        n_first_stamp = r_first_stamp;
        n_awaiting    = r_awaiting;
        n_flags       = r_flags;
        unique case (i_event.req_type)
            REQ_FRAME_RST: begin
                n_flags = '0;
            end
            REQ_DOWN: begin
                n_flags.down_seen = 1'b1;
                n_press_x         = i_event.pos_x;
                n_press_y         = i_event.pos_y;
                n_press_stamp     = i_event.stamp_ms;
            end
            REQ_UP: begin
                n_flags.up_seen = 1'b1;
                if (!w_click_ok) begin
                    n_flags.click        = 1'b0;
                    n_flags.double_click = 1'b0;
                    n_awaiting           = 1'b0;
                end else if (!r_awaiting || !w_double_ok) begin
                    // first click, or second one too far or too late: re-arm
                    n_flags.click        = 1'b1;
                    n_flags.double_click = 1'b0;
                    n_awaiting           = 1'b1;
                    n_first_x            = r_press_x;
                    n_first_y            = r_press_y;
                    n_first_stamp        = i_event.stamp_ms;
                end else begin
                    n_flags.click        = 1'b1;
                    n_flags.double_click = 1'b1;
                    n_awaiting           = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_x     <= '0;
            r_press_y     <= '0;
            r_press_stamp <= '0;
            r_first_x     <= '0;
            r_first_y     <= '0;
            r_first_stamp <= '0;
            r_awaiting    <= 1'b0;
            r_flags       <= '0;
        end else if (i_step) begin
            r_press_x     <= n_press_x;
            r_press_y     <= n_press_y;
            r_press_stamp <= n_press_stamp;
            r_first_x     <= n_first_x;
            r_first_y     <= n_first_y;
            r_first_stamp <= n_first_stamp;
            r_awaiting    <= n_awaiting;
            r_flags       <= n_flags;
        end
    end

    assign o_flags = n_flags;

    a_double_needs_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.double_click |-> r_flags.click)
        else $error("double click flag without click flag");

    a_double_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.double_click |-> !r_awaiting)
        else $error("pending mark still armed after double click");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_event.req_type == REQ_FRAME_RST)) |=> (r_flags == '0))
        else $error("frame reset left a flag set");

    a_up_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_event.req_type == REQ_UP)) |=> r_flags.up_seen)
        else $error("release beat did not set up_seen");

    a_arm_on_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_event.req_type == REQ_UP) && w_click_ok && !r_awaiting)
        |=> (r_awaiting && r_flags.click))
        else $error("first click did not arm the pending mark");

endmodule

// ===== hw/rtl/click_double_click_detector_top.sv =====
// top level of the click and double-click detector with input and result registers
//
// usage
// - input channel (i_valid, o_ready, i_event) carries one button event per beat:
//   frame reset, button down or button up, with position and millisecond stamp
// - output channel (o_valid, i_ready, o_flags) returns exactly one beat of four
//   frame flags per input beat, in order
// - limits must be written through i_cfg_we / i_cfg_index / i_cfg_data while no beat
//   is in flight (the block does not check); indexes off the register list are ignored
// pipeline and throughput
// - an input beat lands in the input register, is evaluated against the stored
//   press and first-click state once the result register is free, and loads it:
//   o_valid rises with the result register load, result taken while i_ready is high
// - one beat per cycle sustained while i_ready stays high; the state update is a
//   single pass of two distance adders and two stamp subtractors with compares
// reset and stalls
// - reset empties both pipeline registers, clears the press and first-click state
//   and all flags, and loads the default limits
// - when the receiver holds i_ready low the result register holds, the input
//   register fills, and o_ready then drops until the result beat is taken
module click_double_click_detector_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  cdcd_pkg::t_event                 i_event,
    output logic                             o_valid,
    input  logic                             i_ready,
    output cdcd_pkg::t_flags                 o_flags,
    input  logic                             i_cfg_we,
    input  logic [cdcd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cdcd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cdcd_pkg::*;

    logic   r_in_valid;
    t_event r_in;
    logic   r_out_valid;
    t_flags r_out;

    t_cfg   w_cfg;
    t_flags w_flags;
    logic   w_step;

    assign w_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    cdcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    cdcd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_event (r_in),
        .i_cfg   (w_cfg),
        .o_flags (w_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_event;
        end
        if (w_step) begin
            r_out <= w_flags;
        end
    end

    assign o_valid = r_out_valid;
    assign o_flags = r_out;

endmodule
